// ----- rtl/fsfl_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fsfl_pkg
// Shared types and constants of the fixed-slot free-list allocator.
// ============================================================================
package fsfl_pkg;

    // Field widths of the request, response and configuration beats
    localparam int OP_W       = 1;
    localparam int SLOT_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 9;
    localparam int SIZE_W     = 16;
    localparam int BYTES_W    = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 9'd256;
    localparam logic [SIZE_W-1:0]  SLOT_SIZE_RST  = 16'd64;

    // Allocated count saturates here
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_COUNT = 1'b0,
        CFG_SLOT_SIZE  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

endpackage

// ----- rtl/fsfl_req_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fsfl_req_if
// Request channel: one beat is an allocate or a free.
// ============================================================================
interface fsfl_req_if;
    logic                        valid;
    logic                        ready;
    logic [fsfl_pkg::OP_W-1:0]   operation;
    logic [fsfl_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output operation, output slot, input ready);
    modport sink   (input valid, input operation, input slot, output ready);
endinterface

// ----- rtl/fsfl_rsp_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fsfl_rsp_if
// Response channel: one beat per request with slot, status and usage totals.
// ============================================================================
interface fsfl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fsfl_pkg::SLOT_W-1:0]   granted_slot;
    logic [fsfl_pkg::STATUS_W-1:0] status;
    logic [fsfl_pkg::COUNT_W-1:0]  allocated_count;
    logic [fsfl_pkg::BYTES_W-1:0]  allocated_bytes;

    modport source (output valid, output granted_slot, output status,
                    output allocated_count, output allocated_bytes, input ready);
    modport sink   (input valid, input granted_slot, input status,
                    input allocated_count, input allocated_bytes, output ready);
endinterface

// ----- rtl/fsfl_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fsfl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module fsfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fixed_slot_free_list_allocator.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fixed_slot_free_list_allocator
// Pool of equal-size slots handed out and taken back through a LIFO free list.
// ============================================================================
// Usage:
//   i_req carries one beat per request: operation (0 allocate, 1 free) and the
//   slot to free. o_rsp returns exactly one beat per request with the granted
//   slot, a status (ok, out of slots, freed slot out of range) and the number
//   of allocated slots and bytes after that request.
//   The free list links live in a one-port-write, one-port-read RAM of
//   MAX_SLOTS entries. A free or an allocate on an empty list is answered
//   from the idle state; an allocate that pops the list also passes through
//   the pop state, since the link of the head slot comes out of the RAM's
//   registered read port. The response sits in an output register; a new
//   request is taken in the cycle that register is empty or being drained,
//   so a stalled receiver holds off the request side after one waiting beat.
//   After reset and after every configuration write the list is rebuilt in
//   ascending slot order by a pass over all MAX_SLOTS link entries, one entry
//   per cycle; no request is taken during that pass.
//   Configuration writes: index 0 slot_count, index 1 slot_size; both clear
//   the allocated totals.
// ============================================================================
module fixed_slot_free_list_allocator #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fsfl_req_if.sink                            i_req,
    fsfl_rsp_if.source                          o_rsp,
    input  logic                                i_cfg_we,
    input  logic [fsfl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fsfl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int LW = IW + 1;
    localparam int PW = fsfl_pkg::COUNT_W + fsfl_pkg::SIZE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SLOTS - 1);

    // Control state
    fsfl_pkg::t_state                r_state, n_state;
    logic                            r_building, n_building;
    logic [IW-1:0]                   r_bld_idx, n_bld_idx;
    logic [fsfl_pkg::COUNT_W-1:0]    r_slot_count, n_slot_count;
    logic [fsfl_pkg::SIZE_W-1:0]     r_slot_size, n_slot_size;
    logic [IW-1:0]                   r_head, n_head;
    logic                            r_empty, n_empty;
    logic [fsfl_pkg::COUNT_W-1:0]    r_used, n_used;
    logic [fsfl_pkg::BYTES_W-1:0]    r_bytes, n_bytes;
    logic                            r_out_valid, n_out_valid;

    // Response payload
    logic [fsfl_pkg::SLOT_W-1:0]     r_out_slot, n_out_slot;
    fsfl_pkg::t_status               r_out_status, n_out_status;
    logic [fsfl_pkg::COUNT_W-1:0]    r_out_count, n_out_count;
    logic [fsfl_pkg::BYTES_W-1:0]    r_out_bytes, n_out_bytes;

    // Link RAM ports
    logic                            w_mem_we;
    logic [IW-1:0]                   w_mem_waddr;
    logic [LW-1:0]                   w_mem_wdata;
    logic [LW-1:0]                   w_mem_rdata;

    logic [31:0]                     w_eff;
    logic [31:0]                     w_bld_next;
    logic                            w_acc;
    logic                            w_in_range;
    logic [fsfl_pkg::COUNT_W-1:0]    w_used_upd;
    logic [PW-1:0]                   w_prod;

    fsfl_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_head),
        .o_rdata (w_mem_rdata)
    );

    // Effective slot count: zero reads as one, clipped at MAX_SLOTS
    always_comb begin
        w_eff = 32'(r_slot_count);
        if (w_eff == 32'd0) begin
            w_eff = 32'd1;
        end
        if (w_eff > 32'(MAX_SLOTS)) begin
            w_eff = 32'(MAX_SLOTS);
        end
    end

    assign w_bld_next = 32'(r_bld_idx) + 32'd1;
    assign w_in_range = (32'(i_req.slot) < w_eff);

    // Handshake
    assign i_req.ready = (r_state == fsfl_pkg::S_IDLE) && !r_building &&
                         (!r_out_valid || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;

    // Count after a pop (saturating up) or a push (saturating at zero)
    always_comb begin
        if (r_state == fsfl_pkg::S_POP) begin
            w_used_upd = (r_used < fsfl_pkg::COUNT_MAX) ? r_used + 1'b1 : r_used;
        end else begin
            w_used_upd = (r_used != '0) ? r_used - 1'b1 : r_used;
        end
    end

    assign w_prod = PW'(w_used_upd) * PW'(r_slot_size);

    // Next state, list update and response load
    always_comb begin
        n_state      = r_state;
        n_building   = r_building;
        n_bld_idx    = r_bld_idx;
        n_slot_count = r_slot_count;
        n_slot_size  = r_slot_size;
        n_head       = r_head;
        n_empty      = r_empty;
        n_used       = r_used;
        n_bytes      = r_bytes;
        n_out_valid  = r_out_valid;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_bytes  = r_out_bytes;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_bld_idx;
        w_mem_wdata  = {(w_bld_next >= w_eff), IW'(w_bld_next)};

        // response drained
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        // rebuild pass: entry i links to i+1, last one ends the list
        if (r_building) begin
            w_mem_we = 1'b1;
            if (r_bld_idx == LAST_IDX) begin
                n_building = 1'b0;
            end else begin
                n_bld_idx = r_bld_idx + 1'b1;
            end
        end

        unique case (r_state)
            fsfl_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_out_slot  = '0;
                    n_out_count = r_used;
                    n_out_bytes = r_bytes;
                    if (fsfl_pkg::t_op'(i_req.operation) == fsfl_pkg::OP_FREE) begin
                        n_out_valid = 1'b1;
                        if (!w_in_range) begin
                            n_out_status = fsfl_pkg::ST_RANGE;
                        end else begin
                            // push: freed slot links to the old head
                            w_mem_we     = 1'b1;
                            w_mem_waddr  = IW'(i_req.slot);
                            w_mem_wdata  = {r_empty, r_head};
                            n_head       = IW'(i_req.slot);
                            n_empty      = 1'b0;
                            n_used       = w_used_upd;
                            n_bytes      = w_prod[fsfl_pkg::BYTES_W-1:0];
                            n_out_status = fsfl_pkg::ST_OK;
                            n_out_count  = w_used_upd;
                            n_out_bytes  = w_prod[fsfl_pkg::BYTES_W-1:0];
                        end
                    end else if (r_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_status = fsfl_pkg::ST_EMPTY;
                    end else begin
                        // link of the head is read this cycle
                        n_state = fsfl_pkg::S_POP;
                    end
                end
            end
            fsfl_pkg::S_POP: begin
                // pop: head moves to its link, or the list runs empty
                if (w_mem_rdata[LW-1]) begin
                    n_empty = 1'b1;
                    n_head  = '0;
                end else begin
                    n_head  = w_mem_rdata[IW-1:0];
                end
                n_used       = w_used_upd;
                n_bytes      = w_prod[fsfl_pkg::BYTES_W-1:0];
                n_out_valid  = 1'b1;
                n_out_slot   = fsfl_pkg::SLOT_W'(r_head);
                n_out_status = fsfl_pkg::ST_OK;
                n_out_count  = w_used_upd;
                n_out_bytes  = w_prod[fsfl_pkg::BYTES_W-1:0];
                n_state      = fsfl_pkg::S_IDLE;
            end
            default: begin
                n_state = fsfl_pkg::S_IDLE;
            end
        endcase

        // configuration write restarts the list
        if (i_cfg_we) begin
            unique case (fsfl_pkg::t_cfg_idx'(i_cfg_idx))
                fsfl_pkg::CFG_SLOT_COUNT: begin
                    n_slot_count = i_cfg_data[fsfl_pkg::COUNT_W-1:0];
                end
                fsfl_pkg::CFG_SLOT_SIZE: begin
                    n_slot_size = i_cfg_data[fsfl_pkg::SIZE_W-1:0];
                end
                default: begin
                    n_slot_size = r_slot_size;
                end
            endcase
            n_building = 1'b1;
            n_bld_idx  = '0;
            n_head     = '0;
            n_empty    = 1'b0;
            n_used     = '0;
            n_bytes    = '0;
        end
    end

    // State machine register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsfl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_building   <= 1'b1;
            r_bld_idx    <= '0;
            r_slot_count <= fsfl_pkg::SLOT_COUNT_RST;
            r_slot_size  <= fsfl_pkg::SLOT_SIZE_RST;
            r_head       <= '0;
            r_empty      <= 1'b0;
            r_used       <= '0;
            r_bytes      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_building   <= n_building;
            r_bld_idx    <= n_bld_idx;
            r_slot_count <= n_slot_count;
            r_slot_size  <= n_slot_size;
            r_head       <= n_head;
            r_empty      <= n_empty;
            r_used       <= n_used;
            r_bytes      <= n_bytes;
            r_out_valid  <= n_out_valid;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_bytes  <= n_out_bytes;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.granted_slot    = r_out_slot;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.allocated_count = r_out_count;
    assign o_rsp.allocated_bytes = r_out_bytes;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the fixed-slot free-list allocator.
// A transaction-level model of the LIFO pool predicts every response beat. Requests
// are driven with random gaps and the response side stalls at random.
// The stimulus covers fixed corner sequences, random alloc/free mixes under
// several pool settings, a long receiver hold-off, and the allocated-count
// ceiling reached through a self-linked slot.
// ============================================================================
module testbench;
    import fsfl_pkg::*;

    localparam int MAX_SLOTS = 256;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] bytes;
    } t_pool_result;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fsfl_req_if req_ch ();
    fsfl_rsp_if rsp_ch ();

    fixed_slot_free_list_allocator #(
        .MAX_SLOTS (MAX_SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Pool model state
    logic [SLOT_W-1:0]  link_mem [MAX_SLOTS];
    logic               link_last [MAX_SLOTS];
    logic [SLOT_W-1:0]  free_head;
    logic               pool_empty;
    logic [COUNT_W-1:0] busy_slots;
    logic [BYTES_W-1:0] busy_bytes;
    logic [COUNT_W-1:0] cfg_slot_count;
    logic [SIZE_W-1:0]  cfg_slot_size;

    t_pool_result      pending_results [$];
    logic [SLOT_W-1:0] held_slots [$];

    int unsigned errors       = 0;
    int unsigned n_requests   = 0;
    int unsigned n_grants     = 0;
    int unsigned n_frees      = 0;
    int unsigned n_out_of_mem = 0;
    int unsigned n_rejects    = 0;
    int unsigned n_settings   = 0;
    int unsigned n_beats_out  = 0;

    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    int unsigned hold_request = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #15_000_000;
        $display("Timeout: %0d response beats still pending", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------------
    function automatic int unsigned usable_slots();
        if (cfg_slot_count == 0) return 1;
        if (cfg_slot_count > MAX_SLOTS) return MAX_SLOTS;
        return cfg_slot_count;
    endfunction

    function automatic void refresh_bytes();
        logic [31:0] prod;
        prod = 32'(busy_slots) * 32'(cfg_slot_size);
        busy_bytes = prod[BYTES_W-1:0];
    endfunction

    // Ascending chain 0 -> 1 -> ... -> count-1, totals cleared
    function automatic void pool_rebuild();
        int unsigned lim;
        lim = usable_slots();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            link_mem[i]  = '0;
            link_last[i] = 1'b1;
        end
        for (int i = 0; i + 1 < lim; i++) begin
            link_mem[i]  = SLOT_W'(i + 1);
            link_last[i] = 1'b0;
        end
        free_head  = '0;
        pool_empty = 1'b0;
        busy_slots = '0;
        busy_bytes = '0;
    endfunction

    function automatic t_pool_result pool_step(t_op op, logic [SLOT_W-1:0] slot);
        t_pool_result r;
        r.slot   = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (pool_empty) begin
                r.status = ST_EMPTY;
            end else begin
                r.slot = free_head;
                if (link_last[free_head]) begin
                    pool_empty = 1'b1;
                    free_head  = '0;
                end else begin
                    free_head = link_mem[free_head];
                end
                if (busy_slots != COUNT_MAX) busy_slots = busy_slots + 1'b1;
                refresh_bytes();
            end
        end else if (slot >= usable_slots()) begin
            r.status = ST_RANGE;
        end else begin
            // push onto the head; a double free is pushed again
            link_mem[slot]  = free_head;
            link_last[slot] = pool_empty;
            free_head       = slot;
            pool_empty      = 1'b0;
            if (busy_slots != 0) busy_slots = busy_slots - 1'b1;
            refresh_bytes();
        end
        r.count = busy_slots;
        r.bytes = busy_bytes;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(t_op op, logic [SLOT_W-1:0] slot);
        int unsigned  gap;
        t_pool_result r;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.slot      <= slot;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        r = pool_step(op, slot);
        pending_results.push_back(r);
        n_requests++;
        case (r.status)
            ST_EMPTY: n_out_of_mem++;
            ST_RANGE: n_rejects++;
            default: begin
                if (op == OP_ALLOC) begin
                    n_grants++;
                    held_slots.push_back(r.slot);
                end else begin
                    n_frees++;
                    for (int i = 0; i < held_slots.size(); i++) begin
                        if (held_slots[i] == slot) begin
                            held_slots.delete(i);
                            break;
                        end
                    end
                end
            end
        endcase
    endtask

    // Stop offering and wait for every outstanding response beat
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Both registers written back to back while idle
    task automatic set_pool(int unsigned count, int unsigned size);
        drain_requests();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SLOT_COUNT;
        i_cfg_data <= CFG_DATA_W'(count);
        @(posedge i_clk);
        cfg_slot_count = COUNT_W'(count);
        pool_rebuild();
        i_cfg_idx  <= CFG_SLOT_SIZE;
        i_cfg_data <= CFG_DATA_W'(size);
        @(posedge i_clk);
        cfg_slot_size = SIZE_W'(size);
        pool_rebuild();
        i_cfg_we <= 1'b0;
        held_slots.delete();
        n_settings++;
    endtask

    task automatic run_random(int unsigned items, int unsigned alloc_pct);
        int unsigned       pick;
        logic [SLOT_W-1:0] s;
        for (int unsigned k = 0; k < items; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                send_request(OP_ALLOC, SLOT_W'($urandom()));
            end else begin
                // well-formed frees mostly, then double frees and stray slots
                pick = $urandom_range(0, 9);
                if (pick < 7 && held_slots.size() != 0)
                    s = held_slots[$urandom_range(0, held_slots.size() - 1)];
                else if (pick < 8)
                    s = SLOT_W'($urandom_range(0, usable_slots() - 1));
                else
                    s = SLOT_W'($urandom_range(0, 255));
                send_request(OP_FREE, s);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Fixed corner sequences, starting from the reset setting (256 x 64 B)
    task automatic test_pool_corners();
        send_request(OP_ALLOC, 8'hFF);
        send_request(OP_ALLOC, 8'h00);
        send_request(OP_ALLOC, 8'h5A);
        send_request(OP_FREE, 8'd1);
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_FREE, 8'd255);      // never handed out
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_FREE, 8'hAA);
        send_request(OP_FREE, 8'h55);
        // count 0 acts as one slot, zero-byte slots
        set_pool(0, 0);
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_ALLOC, 8'd0);       // out of slots
        send_request(OP_FREE, 8'd1);        // out of range
        send_request(OP_FREE, 8'd255);
        send_request(OP_FREE, 8'd0);
        send_request(OP_FREE, 8'd0);        // double free, count stays at zero
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_ALLOC, 8'd0);       // same slot again via self link
        // oversize count clamps to the pool size
        set_pool(511, 65535);
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_FREE, 8'd255);
        // a small slot size of 3 is used as is
        set_pool(1, 3);
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_FREE, 8'd0);
        send_request(OP_ALLOC, 8'd0);
    endtask

    task automatic test_random_mixes();
        set_pool(256, $urandom_range(4, 65535));
        run_random(200, 60);
        set_pool(2, 4);
        run_random(80, 50);
        set_pool($urandom_range(2, 32), $urandom_range(0, 65535));
        run_random(150, 55);
        // a stretch with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_pool(511, 65535);
        run_random(150, 70);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_pool($urandom_range(1, 300), $urandom_range(0, 65535));
        run_random(170, 55);
    endtask

    // Receiver holds off while requests keep coming back to back
    task automatic test_backpressure();
        set_pool(256, 64);
        tx_idle_on   = 1'b0;
        hold_request = 80;
        run_random(40, 65);
        tx_idle_on = 1'b1;
    endtask

    // One slot linked to itself lets the count climb to its ceiling
    task automatic test_count_ceiling();
        set_pool(1, 65535);
        send_request(OP_FREE, 8'd0);
        repeat (515) send_request(OP_ALLOC, SLOT_W'($urandom()));
        repeat (3) send_request(OP_FREE, 8'd0);
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stalls plus requested long holds
    // ------------------------------------------------------------------------
    initial begin : rsp_ready_driver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    // Compare each response beat with the oldest prediction
    always @(posedge i_clk) begin : check_responses
        t_pool_result want;
        t_pool_result got;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.slot   = rsp_ch.granted_slot;
            got.status = rsp_ch.status;
            got.count  = rsp_ch.allocated_count;
            got.bytes  = rsp_ch.allocated_bytes;
            n_beats_out++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected beat slot=%0d status=%0d count=%0d bytes=%0d",
                             $realtime, got.slot, got.status, got.count, got.bytes);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: beat %0d mismatch", $realtime, n_beats_out);
                        $display("  exp slot=%0d status=%0d count=%0d bytes=%0d",
                                 want.slot, want.status, want.count, want.bytes);
                        $display("  got slot=%0d status=%0d count=%0d bytes=%0d",
                                 got.slot, got.status, got.count, got.bytes);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned waited;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_SLOT_COUNT;
        i_cfg_data       <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_ALLOC;
        req_ch.slot      <= '0;
        cfg_slot_count = SLOT_COUNT_RST;
        cfg_slot_size  = SLOT_SIZE_RST;
        pool_rebuild();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_pool_corners();
        test_random_mixes();
        test_backpressure();
        test_count_ceiling();

        // let the last beats out, with a limit
        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0d predicted beats never arrived", pending_results.size());
            errors += pending_results.size();
        end
        repeat (20) @(posedge i_clk);

        $display("Ran %0d requests over %0d pool settings: %0d grants, %0d frees,",
                 n_requests, n_settings + 1, n_grants, n_frees);
        $display("%0d out-of-slot allocs, %0d out-of-range frees, %0d mismatches",
                 n_out_of_mem, n_rejects, errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
